// ===== hdl/jkvl_pkg.sv =====
// Shared types and constants of the JSON key/value locator.
// Used by the front classifier, the back scanner and the top level.
package jkvl_pkg;

  localparam int unsigned POS_W = 12;
  localparam int unsigned CNT_W = 12;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [2:0] CFG_WANTED_INDEX = 3'd0;
  localparam logic [2:0] CFG_KEY_LENGTH   = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD0    = 3'd2;

  typedef enum logic [3:0] {
    CL_OTHER  = 4'd0,
    CL_NUL    = 4'd1,
    CL_QUOTE  = 4'd2,
    CL_COLON  = 4'd3,
    CL_COMMA  = 4'd4,
    CL_LBRACE = 4'd5,
    CL_RBRACE = 4'd6,
    CL_LBRACK = 4'd7,
    CL_RBRACK = 4'd8,
    CL_BLANK  = 4'd9
  } cls_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_TEXT  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] key_start;
    logic [CNT_W-1:0] key_length_res;
    logic [POS_W-1:0] value_start;
    logic [CNT_W-1:0] value_length;
  } res_t;

endpackage

// ===== hdl/jkvl_fifo.sv =====
// Small register-based first-in first-out queue with push/full and pop/empty.
// Generic in width and depth; no package dependency.
module jkvl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/jkvl_front.sv =====
// Front part of the locator: classifies each accepted text byte and queues
// the classified token for the scanner. Depends on jkvl_pkg and jkvl_fifo.
module jkvl_front
  import jkvl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       tok_pop,
  output logic       tok_empty,
  output tok_t       tok
);

  tok_t                  tok_in;
  logic [$bits(tok_t)-1:0] tok_bits;

  always_comb begin
    tok_in.data = in_data_byte;
    case (in_data_byte)
      CH_NUL:    tok_in.cls = CL_NUL;
      CH_QUOTE:  tok_in.cls = CL_QUOTE;
      CH_COLON:  tok_in.cls = CL_COLON;
      CH_COMMA:  tok_in.cls = CL_COMMA;
      CH_LBRACE: tok_in.cls = CL_LBRACE;
      CH_RBRACE: tok_in.cls = CL_RBRACE;
      CH_LBRACK: tok_in.cls = CL_LBRACK;
      CH_RBRACK: tok_in.cls = CL_RBRACK;
      default: begin
        tok_in.cls = (in_data_byte inside {CH_SPACE, [CH_TAB:CH_CR]}) ? CL_BLANK : CL_OTHER;
      end
    endcase
  end

  jkvl_fifo #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .wr_data (tok_in),
    .pop     (tok_pop),
    .empty   (tok_empty),
    .rd_data (tok_bits)
  );

  assign tok = tok_t'(tok_bits);

endmodule

// ===== hdl/jkvl_scan.sv =====
// Back part of the locator: configuration registers and the scan state
// machine that turns classified tokens into result records. Uses jkvl_pkg.
module jkvl_scan
  import jkvl_pkg::*;
#(
  parameter int unsigned MAX_DOC_BYTES = 4096,
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        tok_empty,
  output logic        tok_pop,
  input  tok_t        tok,
  input  logic        res_full,
  output logic        res_push,
  output res_t        res
);

  localparam int unsigned OFF_W = $clog2(MAX_DOC_BYTES + 1);
  localparam int unsigned KIW   = $clog2(MAX_KEY_BYTES);
  localparam logic [OFF_W-1:0] DOC_LIM = OFF_W'(MAX_DOC_BYTES);
  localparam logic [5:0]       KEY_LIM = 6'(MAX_KEY_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [5:0] {
    PH_KEY_OPEN = 6'b000001,
    PH_KEY      = 6'b000010,
    PH_COLON    = 6'b000100,
    PH_VALUE    = 6'b001000,
    PH_STRING   = 6'b010000,
    PH_BRACKET  = 6'b100000
  } phase_t;

  logic signed [12:0] wanted_r;
  logic [5:0]         key_len_r;
  logic [7:0]         key_r [MAX_KEY_BYTES];

  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic [POS_W-1:0] key_begin_r, key_begin_nxt;
  logic [CNT_W-1:0] key_chars_r, key_chars_nxt;
  logic [POS_W-1:0] value_begin_r, value_begin_nxt;
  logic [CNT_W-1:0] pairs_r, pairs_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic             brace_r, brace_nxt;
  logic             match_r, match_nxt;
  logic             answered_r, answered_nxt;

  logic             by_name, hit, key_ok, finish, emit, restart, is_nul;
  logic             is_open, is_close;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] depth_dec;
  logic [KIW-1:0]   key_idx;

  assign by_name = &wanted_r;
  assign hit     = by_name || (!wanted_r[12] && pairs_r == wanted_r[11:0]);
  assign pos     = POS_W'(offset_r);
  assign is_nul  = (tok.cls == CL_NUL);
  assign key_idx = key_chars_r[KIW-1:0];
  assign key_ok  = (key_chars_r < {{(CNT_W-6){1'b0}}, key_len_r}) && (key_len_r <= KEY_LIM)
                   && (key_r[key_idx] == tok.data);
  assign is_open  = brace_r ? (tok.cls == CL_LBRACE) : (tok.cls == CL_LBRACK);
  assign is_close = brace_r ? (tok.cls == CL_RBRACE) : (tok.cls == CL_RBRACK);
  assign depth_dec = (depth_r != '0) ? depth_r - 1'b1 : '0;

  always_comb begin
    phase_nxt       = phase_r;
    offset_nxt      = offset_r;
    key_begin_nxt   = key_begin_r;
    key_chars_nxt   = key_chars_r;
    value_begin_nxt = value_begin_r;
    pairs_nxt       = pairs_r;
    depth_nxt       = depth_r;
    brace_nxt       = brace_r;
    match_nxt       = match_r;
    answered_nxt    = answered_r;
    finish          = 1'b0;
    emit            = 1'b0;
    restart         = 1'b0;
    res             = '0;
    tok_pop         = !tok_empty && !res_full;

    if (tok_pop) begin
      if (answered_r) begin
        restart = is_nul;
      end else if (!is_nul && offset_r >= DOC_LIM) begin
        answered_nxt = 1'b1;
        emit         = 1'b1;
        res.status   = ST_TOO_LONG;
      end else begin
        case (phase_r)
          PH_KEY_OPEN: begin
            if (tok.cls == CL_QUOTE) begin
              key_begin_nxt = pos + 1'b1;
              key_chars_nxt = '0;
              match_nxt     = 1'b1;
              phase_nxt     = PH_KEY;
            end
          end
          PH_KEY: begin
            if (tok.cls == CL_QUOTE) begin
              if (by_name && (key_chars_r == '0 || !match_r
                              || key_chars_r != {{(CNT_W-6){1'b0}}, key_len_r})) begin
                phase_nxt = PH_KEY_OPEN;
              end else begin
                phase_nxt = PH_COLON;
              end
            end else begin
              if (match_r && !key_ok) begin
                match_nxt = 1'b0;
              end
              if (key_chars_r != CNT_MAX) begin
                key_chars_nxt = key_chars_r + 1'b1;
              end
            end
          end
          PH_COLON: begin
            if (tok.cls == CL_COLON) begin
              value_begin_nxt = pos + 1'b1;
              phase_nxt       = PH_VALUE;
            end else if (tok.cls != CL_BLANK) begin
              emit       = 1'b1;
              res.status = ST_BAD_TEXT;
            end
          end
          PH_VALUE: begin
            if (tok.cls == CL_QUOTE) begin
              value_begin_nxt = pos + 1'b1;
              phase_nxt       = PH_STRING;
            end else if (tok.cls inside {CL_COMMA, CL_NUL, CL_RBRACE, CL_RBRACK}) begin
              finish = 1'b1;
            end else if (tok.cls == CL_LBRACE || tok.cls == CL_LBRACK) begin
              brace_nxt       = (tok.cls == CL_LBRACE);
              depth_nxt       = CNT_W'(1);
              value_begin_nxt = pos + 1'b1;
              phase_nxt       = PH_BRACKET;
            end
          end
          PH_STRING: begin
            finish = (tok.cls == CL_QUOTE);
          end
          PH_BRACKET: begin
            if (is_open) begin
              if (depth_r != CNT_MAX) begin
                depth_nxt = depth_r + 1'b1;
              end
            end else if (is_close) begin
              depth_nxt = depth_dec;
              finish    = (depth_dec == '0);
            end
          end
          default: begin
            phase_nxt = PH_KEY_OPEN;
          end
        endcase

        if (finish) begin
          if (pairs_r != CNT_MAX) begin
            pairs_nxt = pairs_r + 1'b1;
          end
          phase_nxt = PH_KEY_OPEN;
          if (hit) begin
            emit               = 1'b1;
            res.status         = ST_FOUND;
            res.key_start      = key_begin_r;
            res.key_length_res = key_chars_r;
            res.value_start    = value_begin_r;
            res.value_length   = pos - value_begin_r;
          end
        end

        if (is_nul) begin
          if (!emit) begin
            emit       = 1'b1;
            res        = '0;
            res.status = ST_NOT_FOUND;
          end
          restart = 1'b1;
        end else begin
          if (emit) begin
            answered_nxt = 1'b1;
          end
          offset_nxt = offset_r + 1'b1;
        end
      end
    end

    if (restart) begin
      phase_nxt       = PH_KEY_OPEN;
      offset_nxt      = '0;
      key_begin_nxt   = '0;
      key_chars_nxt   = '0;
      value_begin_nxt = '0;
      pairs_nxt       = '0;
      depth_nxt       = '0;
      brace_nxt       = 1'b0;
      match_nxt       = 1'b1;
      answered_nxt    = 1'b0;
    end
  end

  assign res_push = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_KEY_OPEN;
      offset_r      <= '0;
      key_begin_r   <= '0;
      key_chars_r   <= '0;
      value_begin_r <= '0;
      pairs_r       <= '0;
      depth_r       <= '0;
      brace_r       <= 1'b0;
      match_r       <= 1'b1;
      answered_r    <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      offset_r      <= offset_nxt;
      key_begin_r   <= key_begin_nxt;
      key_chars_r   <= key_chars_nxt;
      value_begin_r <= value_begin_nxt;
      pairs_r       <= pairs_nxt;
      depth_r       <= depth_nxt;
      brace_r       <= brace_nxt;
      match_r       <= match_nxt;
      answered_r    <= answered_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r  <= '1;
      key_len_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WANTED_INDEX) begin
        wanted_r <= signed'(cfg_data[12:0]);
      end
      if (cfg_index == CFG_KEY_LENGTH) begin
        key_len_r <= cfg_data[5:0];
      end
    end
  end

  for (genvar gb = 0; gb < MAX_KEY_BYTES; gb++) begin : g_key_byte
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[gb] <= '0;
      end else if (cfg_we && cfg_index == CFG_KEY_WORD0 + 3'(gb / 8)) begin
        key_r[gb] <= cfg_data[8*(gb % 8) +: 8];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_quiet_after_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && answered_r) |-> !res_push)
    else $error("result produced after the document was already answered");

  a_end_always_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && is_nul && !answered_r) |-> res_push)
    else $error("document end without a result");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && is_nul) |=> (offset_r == '0 && phase_r == PH_KEY_OPEN && !answered_r))
    else $error("scan state not cleared after document end");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= DOC_LIM)
    else $error("byte offset ran past the document limit");
`endif

endmodule

// ===== hdl/json_key_value_locator.sv =====
// Top level of the JSON key/value locator: front classifier, back scanner
// and the result queue. Depends on jkvl_pkg, jkvl_front, jkvl_scan, jkvl_fifo.
//
//   Channel   Handshake            Payload
//   in_       in_push / in_full    in_data_byte
//   out_      out_pop / out_empty  out_status, out_key_start, out_key_length_res,
//                                  out_value_start, out_value_length
//   cfg_      cfg_we               cfg_index, cfg_data
//
// One byte is accepted per cycle while the result queue is not full; the scanner
// updates its state byte by byte, setting the sustained rate of one byte per clock.
// A byte passes through the input queue, and its result through the result queue.
// Reset is synchronous; it clears the scan state and both queues and resets the registers.
// A full result queue stalls the scanner, and the input queue then fills.
module json_key_value_locator
  import jkvl_pkg::*;
#(
  parameter int unsigned MAX_DOC_BYTES = 4096,
  parameter int unsigned MAX_KEY_BYTES = 32,
  parameter int unsigned QUEUE_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_status,
  output logic [11:0] out_key_start,
  output logic [11:0] out_key_length_res,
  output logic [11:0] out_value_start,
  output logic [11:0] out_value_length,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  tok_t                    tok;
  logic                    tok_pop, tok_empty;
  res_t                    res, res_q;
  logic                    res_push, res_full;
  logic [$bits(res_t)-1:0] res_bits;

  jkvl_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .tok_pop      (tok_pop),
    .tok_empty    (tok_empty),
    .tok          (tok)
  );

  jkvl_scan #(
    .MAX_DOC_BYTES (MAX_DOC_BYTES),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .tok       (tok),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  jkvl_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (res_full),
    .wr_data (res),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (res_bits)
  );

  assign res_q              = res_t'(res_bits);
  assign out_status         = res_q.status;
  assign out_key_start      = res_q.key_start;
  assign out_key_length_res = res_q.key_length_res;
  assign out_value_start    = res_q.value_start;
  assign out_value_length   = res_q.value_length;

endmodule
